>>> rtl/bounding_box_hierarchy_index_assert.svh
// Assertion helpers used by the index sequencer (bbhi_ctrl).
`ifndef BOUNDING_BOX_HIERARCHY_INDEX_ASSERT_SVH
`define BOUNDING_BOX_HIERARCHY_INDEX_ASSERT_SVH

// Property that must hold on every clock edge outside reset.
`define BBHI_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after its antecedent.
`define BBHI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/bbhi_pkg.sv
`default_nettype none

package bbhi_pkg;

	// Store geometry.
	localparam int CAPACITY     = 4096;
	localparam int LEAF_DEPTH   = CAPACITY;
	localparam int UP_DEPTH     = 768;
	localparam int POS_W        = 12;
	localparam int CNT_W        = 13;
	localparam int LVL_W        = 2;

	localparam logic [CNT_W-1:0] CHANGE_MAX = 13'd8191;
	localparam logic [7:0]       DIV_RESET  = 8'd10;

	// Operation codes.
	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_UPDATE = 3'd1;
	localparam logic [2:0] MODE_DELETE = 3'd2;
	localparam logic [2:0] MODE_QSTART = 3'd3;
	localparam logic [2:0] MODE_QNEXT  = 3'd4;
	localparam logic [2:0] MODE_CLEAR  = 3'd5;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_END  = 2'd2;

	typedef struct packed {
		logic signed [31:0] lo_x;
		logic signed [31:0] lo_y;
		logic signed [31:0] hi_x;
		logic signed [31:0] hi_y;
	} box_t;

	localparam box_t EMPTY_BOX = '{
		lo_x: 32'sh7FFFFFFF, lo_y: 32'sh7FFFFFFF,
		hi_x: 32'sh80000000, hi_y: 32'sh80000000
	};

	typedef struct packed {
		logic [2:0]         mode;
		logic [11:0]        entry_position;
		logic signed [31:0] box_min_x;
		logic signed [31:0] box_min_y;
		logic signed [31:0] box_max_x;
		logic signed [31:0] box_max_y;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [11:0]        assigned_position;
		logic [12:0]        range_start;
		logic [12:0]        range_end;
		logic signed [31:0] extent_min_x;
		logic signed [31:0] extent_min_y;
		logic signed [31:0] extent_max_x;
		logic signed [31:0] extent_max_y;
	} rsp_t;

	// One memory access slot: a read and a write per cycle.
	typedef struct packed {
		logic        rd_en;
		logic [11:0] rd_addr;
		logic        wr_en;
		logic [11:0] wr_addr;
		box_t        wr_data;
	} mem_req_t;

	function automatic logic box_is_empty(input box_t b);
		return (b.lo_x > b.hi_x) || (b.lo_y > b.hi_y);
	endfunction

	function automatic box_t box_union(input box_t a, input box_t b);
		box_t r;
		r = a;
		if (b.lo_x < r.lo_x) r.lo_x = b.lo_x;
		if (b.lo_y < r.lo_y) r.lo_y = b.lo_y;
		if (b.hi_x > r.hi_x) r.hi_x = b.hi_x;
		if (b.hi_y > r.hi_y) r.hi_y = b.hi_y;
		return r;
	endfunction

	function automatic logic box_disjoint(input box_t a, input box_t b);
		return box_is_empty(a) || box_is_empty(b) ||
			(a.lo_x > b.hi_x) || (a.hi_x < b.lo_x) ||
			(a.lo_y > b.hi_y) || (a.hi_y < b.lo_y);
	endfunction

	function automatic logic box_not_inside(input box_t outer, input box_t b);
		return (b.lo_x < outer.lo_x) || (b.hi_x > outer.hi_x) ||
			(b.lo_y < outer.lo_y) || (b.hi_y > outer.hi_y);
	endfunction

	// Lowest level at which the ancestor index of a position becomes zero.
	function automatic logic [LVL_W-1:0] zero_level(input logic [POS_W-1:0] fid);
		if (fid[11:8] != 4'd0) return 2'd3;
		if (fid[7:4] != 4'd0) return 2'd2;
		if (fid != '0) return 2'd1;
		return 2'd0;
	endfunction

endpackage

`default_nettype wire

>>> rtl/bbhi_ram.sv
`default_nettype none

module bbhi_ram #(
	parameter int DEPTH = bbhi_pkg::LEAF_DEPTH,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  bbhi_pkg::mem_req_t req,
	output bbhi_pkg::box_t     rd_data
);
	import bbhi_pkg::*;

	box_t mem [DEPTH];
	box_t rd_q;

	// Synchronous box store with a registered read port.
	always_ff @(posedge clk) begin
		if (req.wr_en) mem[req.wr_addr[AW-1:0]] <= req.wr_data;
		if (req.rd_en) rd_q <= mem[req.rd_addr[AW-1:0]];
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

>>> rtl/bbhi_ctrl.sv
`default_nettype none

module bbhi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  bbhi_pkg::req_t     req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output bbhi_pkg::rsp_t     rsp,
	input  logic               cfg_wr_en,
	input  logic [7:0]         cfg_wr_data,
	output bbhi_pkg::mem_req_t leaf_req,
	output bbhi_pkg::mem_req_t up_req,
	input  bbhi_pkg::box_t     leaf_rd_data,
	input  bbhi_pkg::box_t     up_rd_data
);
	import bbhi_pkg::*;
	`include "bounding_box_hierarchy_index_assert.svh"

	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_DISP   = 5'd1;
	localparam logic [4:0] ST_INS_RD = 5'd2;
	localparam logic [4:0] ST_INS_WR = 5'd3;
	localparam logic [4:0] ST_RS_RD  = 5'd4;
	localparam logic [4:0] ST_RS_ACC = 5'd5;
	localparam logic [4:0] ST_RS_WR  = 5'd6;
	localparam logic [4:0] ST_DEL    = 5'd7;
	localparam logic [4:0] ST_CNT    = 5'd8;
	localparam logic [4:0] ST_RB_RD  = 5'd9;
	localparam logic [4:0] ST_RB_ACC = 5'd10;
	localparam logic [4:0] ST_RB_WR  = 5'd11;
	localparam logic [4:0] ST_Q_CHK  = 5'd12;
	localparam logic [4:0] ST_Q_EV   = 5'd13;
	localparam logic [4:0] ST_Q_UP   = 5'd14;
	localparam logic [4:0] ST_EXT_RD = 5'd15;
	localparam logic [4:0] ST_EXT_WT = 5'd16;
	localparam logic [4:0] ST_DONE   = 5'd17;

	logic [4:0]       state_q;
	logic [2:0]       mode_q;
	logic [POS_W-1:0] pos_q;
	box_t             box_q;
	logic [7:0]       div_q;
	logic [CNT_W-1:0] next_q;
	logic [LVL_W-1:0] root_q;
	logic [CNT_W-1:0] cc_q;
	logic [CNT_W-1:0] cur_idx_q;
	logic [LVL_W-1:0] cur_lvl_q;
	box_t             search_q;
	logic [LVL_W-1:0] lvl_q;
	logic [CNT_W-1:0] idx_q;
	logic [3:0]       cidx_q;
	logic [POS_W-1:0] fid_q;
	logic             upd_q;
	logic [LVL_W-1:0] stop_q;
	logic             raise_q;
	logic             have_q;
	logic [CNT_W-1:0] start_q;
	logic [CNT_W-1:0] end_q;
	box_t             acc_q;
	logic [1:0]       status_q;
	logic [POS_W-1:0] assigned_q;
	logic [CNT_W-1:0] rs_q;
	logic [CNT_W-1:0] re_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic             rd_ok_q;
	logic             rd_leaf_q;

	// Node access signals.
	logic             rd_en;
	logic [LVL_W-1:0] rd_lvl;
	logic [CNT_W-1:0] rd_idx;
	logic             wr_en;
	logic [LVL_W-1:0] wr_lvl;
	logic [CNT_W-1:0] wr_idx;
	box_t             wr_data;
	logic             rd_ok;
	logic [CNT_W-1:0] rd_lim;
	box_t             node_rd;

	logic [CNT_W-1:0] fid_k;
	logic [CNT_W-1:0] rs_old;
	logic [CNT_W-1:0] kmax;
	logic [24:0]      endv;
	logic [CNT_W-1:0] sz;
	logic             past_end;
	logic [CNT_W-1:0] cc_inc;
	logic [20:0]      prod;
	logic             rb_go;
	logic             pos_ok;
	logic             in_empty;
	logic             do_ins;
	logic [LVL_W-1:0] i0_next;
	logic [LVL_W-1:0] i0_pos;
	box_t             in_box;

	// Index arithmetic for the walks.
	assign fid_k  = {1'b0, fid_q} >> {lvl_q, 2'b00};
	assign rs_old = {1'b0, fid_q} >> {stop_q - 2'd1, 2'b00};
	assign kmax   = (next_q - 13'd1) >> {lvl_q, 2'b00};
	assign endv   = {12'b0, idx_q} << {lvl_q, 2'b00};
	assign sz     = (next_q > 13'd1) ? next_q : '0;
	assign past_end = endv >= {12'b0, sz};

	// Change counting and the rebuild threshold, as a product compare.
	assign cc_inc = (cc_q == CHANGE_MAX) ? cc_q : cc_q + 13'd1;
	assign prod   = {8'b0, cc_inc} * {13'b0, div_q};
	assign rb_go  = (div_q != 8'd0) && (next_q >= {5'b0, div_q}) && (prod > {8'b0, next_q});

	// Dispatch decisions.
	assign pos_ok   = (pos_q != '0) && ({1'b0, pos_q} < next_q);
	assign in_empty = box_is_empty(box_q);
	assign do_ins   = (mode_q == MODE_INSERT) ||
		((mode_q == MODE_UPDATE) && !in_empty && !pos_ok);
	assign i0_next  = zero_level(next_q[POS_W-1:0]);
	assign i0_pos   = zero_level(pos_q);

	// Canonical input box.
	always_comb begin
		in_box.lo_x = req.box_min_x;
		in_box.lo_y = req.box_min_y;
		in_box.hi_x = req.box_max_x;
		in_box.hi_y = req.box_max_y;
		if (box_is_empty(in_box)) in_box = EMPTY_BOX;
	end

	// Memory access per state.
	always_comb begin
		rd_en   = 1'b0;
		rd_lvl  = '0;
		rd_idx  = '0;
		wr_en   = 1'b0;
		wr_lvl  = '0;
		wr_idx  = '0;
		wr_data = EMPTY_BOX;
		case (state_q)
			ST_INS_RD: begin
				rd_en  = 1'b1;
				rd_lvl = lvl_q;
				rd_idx = fid_k;
			end
			ST_INS_WR: begin
				wr_en   = 1'b1;
				wr_lvl  = lvl_q;
				wr_idx  = fid_k;
				wr_data = box_union(node_rd, box_q);
			end
			ST_RS_RD: begin
				rd_en  = 1'b1;
				rd_lvl = stop_q - 2'd1;
				rd_idx = idx_q;
			end
			ST_RS_WR: begin
				wr_en   = 1'b1;
				wr_lvl  = stop_q;
				wr_data = acc_q;
			end
			ST_DEL: begin
				wr_en  = 1'b1;
				wr_idx = {1'b0, pos_q};
			end
			ST_RB_RD: begin
				rd_en  = 1'b1;
				rd_lvl = lvl_q - 2'd1;
				rd_idx = {1'b0, idx_q[7:0], cidx_q};
			end
			ST_RB_WR: begin
				wr_en   = 1'b1;
				wr_lvl  = lvl_q;
				wr_idx  = idx_q;
				wr_data = acc_q;
			end
			ST_Q_CHK: begin
				rd_en  = 1'b1;
				rd_lvl = lvl_q;
				rd_idx = idx_q;
			end
			ST_EXT_RD: begin
				rd_en  = 1'b1;
				rd_lvl = root_q;
			end
			default: ;
		endcase
	end

	// A node counts as written only inside the filled range; others read as empty.
	assign rd_lim = (next_q - 13'd1) >> {rd_lvl, 2'b00};
	assign rd_ok  = (rd_lvl == '0) ? ((rd_idx != '0) && (rd_idx < next_q))
		: ((rd_lvl <= root_q) && (rd_idx <= rd_lim));
	assign node_rd = !rd_ok_q ? EMPTY_BOX : (rd_leaf_q ? leaf_rd_data : up_rd_data);

	// Route accesses to the leaf store or the upper-level store.
	always_comb begin
		leaf_req.rd_en   = rd_en && (rd_lvl == '0);
		leaf_req.rd_addr = rd_idx[11:0];
		leaf_req.wr_en   = wr_en && (wr_lvl == '0);
		leaf_req.wr_addr = wr_idx[11:0];
		leaf_req.wr_data = wr_data;
		up_req.rd_en     = rd_en && (rd_lvl != '0);
		up_req.rd_addr   = {2'b00, rd_lvl - 2'd1, rd_idx[7:0]};
		up_req.wr_en     = wr_en && (wr_lvl != '0);
		up_req.wr_addr   = {2'b00, wr_lvl - 2'd1, wr_idx[7:0]};
		up_req.wr_data   = wr_data;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= '0;
			pos_q       <= '0;
			box_q       <= EMPTY_BOX;
			div_q       <= DIV_RESET;
			next_q      <= 13'd1;
			root_q      <= '0;
			cc_q        <= '0;
			cur_idx_q   <= '0;
			cur_lvl_q   <= '0;
			search_q    <= EMPTY_BOX;
			lvl_q       <= '0;
			idx_q       <= '0;
			cidx_q      <= '0;
			fid_q       <= '0;
			upd_q       <= 1'b0;
			stop_q      <= '0;
			raise_q     <= 1'b0;
			have_q      <= 1'b0;
			start_q     <= '0;
			end_q       <= '0;
			acc_q       <= EMPTY_BOX;
			status_q    <= STAT_OK;
			assigned_q  <= '0;
			rs_q        <= '0;
			re_q        <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
			rd_leaf_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) div_q <= cfg_wr_data;
			if (rd_en) begin
				rd_ok_q   <= rd_ok;
				rd_leaf_q <= (rd_lvl == '0);
			end
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						mode_q  <= req.mode;
						pos_q   <= req.entry_position;
						box_q   <= in_box;
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					status_q   <= STAT_OK;
					assigned_q <= '0;
					rs_q       <= '0;
					re_q       <= '0;
					lvl_q      <= '0;
					state_q    <= ST_EXT_RD;
					if (do_ins) begin
						if (next_q >= 13'(CAPACITY)) begin
							status_q <= STAT_FULL;
						end else begin
							fid_q   <= next_q[POS_W-1:0];
							upd_q   <= 1'b0;
							stop_q  <= i0_next;
							raise_q <= i0_next > root_q;
							state_q <= ST_INS_RD;
						end
					end else begin
						case (mode_q)
							MODE_UPDATE: begin
								if (in_empty) begin
									if (pos_ok) state_q <= ST_DEL;
								end else begin
									fid_q   <= pos_q;
									upd_q   <= 1'b1;
									stop_q  <= (i0_pos > root_q) ? i0_pos : root_q;
									raise_q <= 1'b0;
									state_q <= ST_INS_RD;
								end
							end
							MODE_DELETE: begin
								if (pos_ok) state_q <= ST_DEL;
							end
							MODE_QSTART: begin
								search_q  <= box_q;
								cur_idx_q <= '0;
								cur_lvl_q <= root_q;
							end
							MODE_QNEXT: begin
								idx_q   <= cur_idx_q;
								lvl_q   <= cur_lvl_q;
								have_q  <= 1'b0;
								start_q <= '0;
								state_q <= ST_Q_CHK;
							end
							MODE_CLEAR: begin
								next_q    <= 13'd1;
								root_q    <= '0;
								cc_q      <= '0;
								cur_idx_q <= '0;
								cur_lvl_q <= '0;
								search_q  <= EMPTY_BOX;
							end
							default: ;
						endcase
					end
				end
				ST_INS_RD: state_q <= ST_INS_WR;
				ST_INS_WR: begin
					if (lvl_q == stop_q) begin
						if (raise_q) begin
							idx_q   <= '0;
							acc_q   <= box_q;
							state_q <= ST_RS_RD;
						end else if (upd_q) begin
							state_q <= ST_CNT;
						end else begin
							next_q     <= next_q + 13'd1;
							assigned_q <= fid_q;
							state_q    <= ST_EXT_RD;
						end
					end else begin
						lvl_q   <= lvl_q + 2'd1;
						state_q <= ST_INS_RD;
					end
				end
				// New root: gather the older siblings below it.
				ST_RS_RD: state_q <= ST_RS_ACC;
				ST_RS_ACC: begin
					acc_q <= box_union(acc_q, node_rd);
					idx_q <= idx_q + 13'd1;
					state_q <= (idx_q + 13'd1 == rs_old) ? ST_RS_WR : ST_RS_RD;
				end
				ST_RS_WR: begin
					root_q     <= stop_q;
					next_q     <= next_q + 13'd1;
					assigned_q <= fid_q;
					state_q    <= ST_EXT_RD;
				end
				ST_DEL: state_q <= ST_CNT;
				ST_CNT: begin
					if (rb_go && (root_q != '0)) begin
						cc_q    <= '0;
						lvl_q   <= 2'd1;
						idx_q   <= '0;
						cidx_q  <= '0;
						acc_q   <= EMPTY_BOX;
						state_q <= ST_RB_RD;
					end else begin
						cc_q    <= rb_go ? '0 : cc_inc;
						state_q <= ST_EXT_RD;
					end
				end
				// Rebuild: each upper node is the union of its sixteen children.
				ST_RB_RD: state_q <= ST_RB_ACC;
				ST_RB_ACC: begin
					acc_q   <= box_union(acc_q, node_rd);
					cidx_q  <= cidx_q + 4'd1;
					state_q <= (cidx_q == 4'hF) ? ST_RB_WR : ST_RB_RD;
				end
				ST_RB_WR: begin
					acc_q   <= EMPTY_BOX;
					cidx_q  <= '0;
					state_q <= ST_RB_RD;
					if (idx_q == kmax) begin
						idx_q <= '0;
						if (lvl_q == root_q) state_q <= ST_EXT_RD;
						else lvl_q <= lvl_q + 2'd1;
					end else begin
						idx_q <= idx_q + 13'd1;
					end
				end
				// Query walk: check the span, then test the node.
				ST_Q_CHK: begin
					if (past_end) begin
						if (!have_q) begin
							status_q <= STAT_END;
						end else begin
							rs_q      <= start_q;
							re_q      <= sz;
							cur_idx_q <= idx_q;
							cur_lvl_q <= lvl_q;
						end
						state_q <= ST_EXT_RD;
					end else begin
						end_q   <= endv[CNT_W-1:0];
						state_q <= ST_Q_EV;
					end
				end
				ST_Q_EV: begin
					if (box_disjoint(search_q, node_rd)) begin
						if (have_q) begin
							rs_q      <= start_q;
							re_q      <= end_q;
							cur_idx_q <= idx_q;
							cur_lvl_q <= lvl_q;
							state_q   <= ST_EXT_RD;
						end else begin
							idx_q   <= idx_q + 13'd1;
							state_q <= ST_Q_UP;
						end
					end else if ((lvl_q != '0) && box_not_inside(search_q, node_rd)) begin
						lvl_q   <= lvl_q - 2'd1;
						idx_q   <= {idx_q[CNT_W-5:0], 4'b0000};
						state_q <= ST_Q_CHK;
					end else begin
						if (!have_q) begin
							have_q  <= 1'b1;
							start_q <= end_q;
						end
						idx_q   <= idx_q + 13'd1;
						state_q <= ST_Q_UP;
					end
				end
				ST_Q_UP: begin
					if ((idx_q[3:0] == 4'd0) && (lvl_q < root_q)) begin
						lvl_q <= lvl_q + 2'd1;
						idx_q <= idx_q >> 4;
					end else begin
						state_q <= ST_Q_CHK;
					end
				end
				ST_EXT_RD: state_q <= ST_EXT_WT;
				ST_EXT_WT: begin
					acc_q   <= node_rd;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q.status            <= status_q;
						rsp_q.assigned_position <= assigned_q;
						rsp_q.range_start       <= rs_q;
						rsp_q.range_end         <= re_q;
						rsp_q.extent_min_x      <= acc_q.lo_x;
						rsp_q.extent_min_y      <= acc_q.lo_y;
						rsp_q.extent_max_x      <= acc_q.hi_x;
						rsp_q.extent_max_y      <= acc_q.hi_y;
						rsp_valid_q             <= 1'b1;
						state_q                 <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A raised root implies at least one entry is filled.
	`BBHI_ASSERT(a_root_needs_fill, (root_q == '0) || (next_q > 13'd1), "root raised on empty index")
	// The query cursor never sits above the root.
	`BBHI_ASSERT(a_cursor_below_root, cur_lvl_q <= root_q, "cursor level above root")
	// A result appears only from the final state.
	`BBHI_ASSERT(a_rsp_from_done, !$rose(rsp_valid_q) || ($past(state_q) == ST_DONE), "stray result")
	// An accepted item always goes to dispatch next.
	`BBHI_ASSERT_NEXT(a_accept_dispatch, req_valid && !req_stall, state_q == ST_DISP, "lost item")

endmodule

`default_nettype wire

>>> rtl/bounding_box_hierarchy_index.sv
// Flow: dispatch, the work of the item, a root extent read, then the result register.
// Insert and update read and write each level walked (up to 4 levels); a new root
// gathers each older sibling; query_next checks and tests each node visited; a rebuild
// reads sixteen children per upper node written. Throughput: one item at a time.
// Reset: asynchronous, active low; control state clears at once; the box stores are not
// swept, since entries outside the filled range read as empty boxes.
`default_nettype none

module bounding_box_hierarchy_index (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bbhi_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bbhi_pkg::rsp_t rsp,
	input  logic           cfg_wr_en,
	input  logic [7:0]     cfg_wr_data
);
	import bbhi_pkg::*;

	mem_req_t leaf_req;
	mem_req_t up_req;
	box_t     leaf_rd_data;
	box_t     up_rd_data;

	// Sequencer with the output register.
	bbhi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.req          (req),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.rsp          (rsp),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.leaf_req     (leaf_req),
		.up_req       (up_req),
		.leaf_rd_data (leaf_rd_data),
		.up_rd_data   (up_rd_data)
	);

	// Leaf boxes, one per position.
	bbhi_ram #(.DEPTH(LEAF_DEPTH)) u_leaf_ram (
		.clk     (clk),
		.req     (leaf_req),
		.rd_data (leaf_rd_data)
	);

	// Upper-level boxes, three levels of 256 nodes.
	bbhi_ram #(.DEPTH(UP_DEPTH)) u_up_ram (
		.clk     (clk),
		.req     (up_req),
		.rd_data (up_rd_data)
	);

endmodule

`default_nettype wire
